// ----- design/rm2q_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package rm2q_pkg;

	// field and datapath widths
	localparam int QW     = 16;
	localparam int AW     = 18;
	localparam int MAG_W  = AW - 1;
	localparam int SQ_W   = 2 * MAG_W;
	localparam int NRM_W  = SQ_W + 2;
	localparam int FRAC   = 28;
	localparam int RAD_W  = 64;
	localparam int ROOT_W = RAD_W / 2;
	localparam int QUO_W  = 16;
	localparam int NUM_W  = MAG_W + FRAC + 3;
	localparam int LANES  = 4;

	localparam logic signed [AW-1:0] Q_ONE = AW'(16384);
	localparam logic signed [QW-1:0] OUT_ONE = QW'(16384);

	typedef enum logic [1:0] {
		BR_TRACE = 2'd0,
		BR_X     = 2'd1,
		BR_Y     = 2'd2,
		BR_Z     = 2'd3
	} branch_t;

	// payload that rides beside the square root
	typedef struct packed {
		logic signed [LANES-1:0][AW-1:0] q;
		branch_t                         branch;
		logic                            degen;
	} sqrt_side_t;

	// payload that rides beside the dividers
	typedef struct packed {
		logic [LANES-1:0] sign;
		branch_t          branch;
		logic             degen;
	} div_side_t;

endpackage
`default_nettype wire

// ----- design/rm2q_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface mat_if;
	import rm2q_pkg::*;
	logic                 valid;
	logic                 ready;
	logic signed [QW-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;

	modport source(output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
		input ready);
	modport sink(input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
		output ready);
endinterface

interface quat_if;
	import rm2q_pkg::*;
	logic                 valid;
	logic                 ready;
	logic signed [QW-1:0] quat_w, quat_x, quat_y, quat_z;
	logic [1:0]           branch_taken;
	logic                 degenerate;

	modport source(output valid, quat_w, quat_x, quat_y, quat_z, branch_taken, degenerate,
		input ready);
	modport sink(input valid, quat_w, quat_x, quat_y, quat_z, branch_taken, degenerate,
		output ready);
endinterface
`default_nettype wire

// ----- design/rm2q_isqrt.sv -----
`timescale 1ns / 1ps
`default_nettype none
module rm2q_isqrt #(
	parameter int RAD_W = rm2q_pkg::RAD_W,
	parameter int SW    = 8
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 en,
	input  wire logic                 vld_in,
	input  wire logic [RAD_W-1:0]     rad_in,
	input  wire logic [SW-1:0]        side_in,
	output logic                      vld_out,
	output logic [RAD_W/2-1:0]        root_out,
	output logic [SW-1:0]             side_out
);
	localparam int ST = RAD_W / 2;

	logic [RAD_W-1:0] n_s   [0:ST];
	logic [RAD_W-1:0] res_s [0:ST];
	logic [SW-1:0]    side_s[0:ST];
	logic             vld_s [0:ST];

	assign n_s[0]    = rad_in;
	assign res_s[0]  = '0;
	assign side_s[0] = side_in;
	assign vld_s[0]  = vld_in;

	// one result bit per stage
	for (genvar i = 0; i < ST; i++) begin : g_st
		localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (RAD_W - 2 - 2 * i);
		logic [RAD_W-1:0] trial;
		logic             take;
		assign trial = res_s[i] + BIT;
		assign take  = n_s[i] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				n_s[i+1]    <= take ? n_s[i] - trial : n_s[i];
				res_s[i+1]  <= take ? (res_s[i] >> 1) + BIT : res_s[i] >> 1;
				side_s[i+1] <= side_s[i];
			end
		end
	end

	assign vld_out  = vld_s[ST];
	assign root_out = res_s[ST][RAD_W/2-1:0];
	assign side_out = side_s[ST];
endmodule
`default_nettype wire

// ----- design/rm2q_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
module rm2q_div #(
	parameter int NUM_W = rm2q_pkg::NUM_W,
	parameter int DEN_W = rm2q_pkg::ROOT_W,
	parameter int QUO_W = rm2q_pkg::QUO_W,
	parameter int LANES = rm2q_pkg::LANES,
	parameter int SW    = 8
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        en,
	input  wire logic                        vld_in,
	input  wire logic [LANES-1:0][NUM_W-1:0] num_in,
	input  wire logic [DEN_W-1:0]            den_in,
	input  wire logic [SW-1:0]               side_in,
	output logic                             vld_out,
	output logic [LANES-1:0][QUO_W-1:0]      quo_out,
	output logic [SW-1:0]                    side_out
);
	logic [LANES-1:0][NUM_W-1:0] rem_s [0:QUO_W];
	logic [LANES-1:0][QUO_W-1:0] quo_s [0:QUO_W];
	logic [DEN_W-1:0]            den_s [0:QUO_W];
	logic [SW-1:0]               side_s[0:QUO_W];
	logic                        vld_s [0:QUO_W];

	assign rem_s[0]  = num_in;
	assign quo_s[0]  = '0;
	assign den_s[0]  = den_in;
	assign side_s[0] = side_in;
	assign vld_s[0]  = vld_in;

	// one quotient bit per stage, msb first
	for (genvar i = 0; i < QUO_W; i++) begin : g_st
		localparam int K = QUO_W - 1 - i;
		logic [NUM_W-1:0] dsh;
		assign dsh = NUM_W'(den_s[i]) << K;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		for (genvar l = 0; l < LANES; l++) begin : g_ln
			logic take;
			assign take = rem_s[i][l] >= dsh;
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[i+1][l] <= take ? rem_s[i][l] - dsh : rem_s[i][l];
					quo_s[i+1][l] <= {quo_s[i][l][QUO_W-2:0], take};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				den_s[i+1]  <= den_s[i];
				side_s[i+1] <= side_s[i];
			end
		end
	end

	assign vld_out  = vld_s[QUO_W];
	assign quo_out  = quo_s[QUO_W];
	assign side_out = side_s[QUO_W];
endmodule
`default_nettype wire

// ----- design/rotation_matrix_to_quaternion.sv -----
`timescale 1ns / 1ps
`default_nettype none
// a matrix passes stages 1 to 3, the square root, stage 4, the dividers and the output register
// throughput: one matrix per cycle unless stalled; the 32-stage square
// root and the 16-stage per-component dividers are fully pipelined
// the whole pipeline holds while the result waits on a deasserted ready
// reset clears only the stage valid bits; data registers are not reset
module rotation_matrix_to_quaternion (
	input  wire logic clk,
	input  wire logic arst_n,
	mat_if.sink       mat,
	quat_if.source    quat
);
	import rm2q_pkg::*;

	logic en;
	assign en = !quat.valid || quat.ready;
	assign mat.ready = en;

	// stage 1: branch select and unnormalized components
	logic signed [AW-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22, trace;
	logic signed [AW-1:0] arg, arg_c;
	logic signed [LANES-1:0][AW-1:0] qc;
	branch_t br;
	assign e00 = AW'(mat.m00); assign e01 = AW'(mat.m01); assign e02 = AW'(mat.m02);
	assign e10 = AW'(mat.m10); assign e11 = AW'(mat.m11); assign e12 = AW'(mat.m12);
	assign e20 = AW'(mat.m20); assign e21 = AW'(mat.m21); assign e22 = AW'(mat.m22);
	assign trace = e00 + e11 + e22;

	always_comb begin
		if (trace > 0) begin
			br  = BR_TRACE;
			arg = Q_ONE + trace;
			qc  = {e10 - e01, e02 - e20, e21 - e12, arg};
		end else if (e00 > e11 && e00 > e22) begin
			br  = BR_X;
			arg = Q_ONE + e00 - e11 - e22;
			qc  = {e02 + e20, e01 + e10, arg, e21 - e12};
		end else if (e11 > e22) begin
			br  = BR_Y;
			arg = Q_ONE + e11 - e00 - e22;
			qc  = {e12 + e21, arg, e01 + e10, e02 - e20};
		end else begin
			br  = BR_Z;
			arg = Q_ONE + e22 - e00 - e11;
			qc  = {arg, e12 + e21, e02 + e20, e10 - e01};
		end
		arg_c = (arg < 0) ? '0 : arg;
		qc[br] = arg_c;
	end

	logic                            vld_s1, vld_s2, vld_s3;
	logic signed [LANES-1:0][AW-1:0] q_s1, q_s2, q_s3;
	branch_t                         br_s1, br_s2, br_s3;
	logic                            az_s1, az_s2;
	logic [LANES-1:0][SQ_W-1:0]      sq_s2;
	logic [NRM_W-1:0]                nrm_s3;
	logic                            dg_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= mat.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_s1  <= qc;
			br_s1 <= br;
			az_s1 <= (arg_c == '0);
		end
	end

	// stage 2: squared magnitudes
	logic [LANES-1:0][MAG_W-1:0] mag1;
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			mag1[l] = q_s1[l][AW-1] ? MAG_W'(-q_s1[l]) : MAG_W'(q_s1[l]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < LANES; l++) begin
				sq_s2[l] <= mag1[l] * mag1[l];
			end
			q_s2  <= q_s1;
			br_s2 <= br_s1;
			az_s2 <= az_s1;
		end
	end

	// stage 3: squared length and degenerate check
	logic [NRM_W-1:0] nrm;
	assign nrm = NRM_W'(sq_s2[0]) + NRM_W'(sq_s2[1]) + NRM_W'(sq_s2[2]) + NRM_W'(sq_s2[3]);

	always_ff @(posedge clk) begin
		if (en) begin
			nrm_s3 <= nrm;
			dg_s3  <= az_s2 || (nrm == '0);
			q_s3   <= q_s2;
			br_s3  <= br_s2;
		end
	end

	// square root of the length squared in q28
	sqrt_side_t         sq_side_in, sq_side_out;
	logic [RAD_W-1:0]   rad;
	logic               vld_rt;
	logic [ROOT_W-1:0]  root;
	assign sq_side_in = '{q: q_s3, branch: br_s3, degen: dg_s3};
	assign rad = RAD_W'(nrm_s3) << FRAC;

	rm2q_isqrt #(
		.RAD_W(RAD_W),
		.SW   ($bits(sqrt_side_t))
	) u_isqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_in  (vld_s3),
		.rad_in  (rad),
		.side_in (sq_side_in),
		.vld_out (vld_rt),
		.root_out(root),
		.side_out(sq_side_out)
	);

	// stage 4: rounded numerators
	logic                        vld_s4;
	logic [LANES-1:0][NUM_W-1:0] num_s4;
	logic [ROOT_W-1:0]           len_s4;
	div_side_t                   dside_s4;
	logic [LANES-1:0][MAG_W-1:0] mag4;
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			mag4[l] = sq_side_out.q[l][AW-1] ? MAG_W'(-sq_side_out.q[l])
				: MAG_W'(sq_side_out.q[l]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_rt;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < LANES; l++) begin
				num_s4[l]        <= (NUM_W'(mag4[l]) << FRAC) + NUM_W'(root >> 1);
				dside_s4.sign[l] <= sq_side_out.q[l][AW-1];
			end
			len_s4          <= root;
			dside_s4.branch <= sq_side_out.branch;
			dside_s4.degen  <= sq_side_out.degen;
		end
	end

	// per-component division by the length
	div_side_t                   dside_out;
	logic                        vld_dv;
	logic [LANES-1:0][QUO_W-1:0] quo;

	rm2q_div #(
		.NUM_W(NUM_W),
		.DEN_W(ROOT_W),
		.QUO_W(QUO_W),
		.LANES(LANES),
		.SW   ($bits(div_side_t))
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_in  (vld_s4),
		.num_in  (num_s4),
		.den_in  (len_s4),
		.side_in (dside_s4),
		.vld_out (vld_dv),
		.quo_out (quo),
		.side_out(dside_out)
	);

	// output stage: sign, saturation, identity on degenerate
	logic signed [LANES-1:0][QW-1:0] res;
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			if (dside_out.sign[l]) begin
				res[l] = quo[l][QUO_W-1] ? QW'(16'sh8000) : QW'(-quo[l]);
			end else begin
				res[l] = quo[l][QUO_W-1] ? QW'(16'sh7fff) : QW'(quo[l]);
			end
		end
		if (dside_out.degen) begin
			res = {QW'(0), QW'(0), QW'(0), OUT_ONE};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quat.valid <= 1'b0;
		end else if (en) begin
			quat.valid <= vld_dv;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quat.quat_w       <= res[0];
			quat.quat_x       <= res[1];
			quat.quat_y       <= res[2];
			quat.quat_z       <= res[3];
			quat.branch_taken <= dside_out.branch;
			quat.degenerate   <= dside_out.degen;
		end
	end
endmodule
`default_nettype wire
